>>> rtl/cssu_pkg.sv
package cssu_pkg;

  // Default sizes of the line store and the row counter.
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Fixed field widths.
  localparam int unsigned XW     = 10;
  localparam int unsigned YW     = 12;
  localparam int unsigned CHW    = 8;
  localparam int unsigned FW_W   = 11;
  localparam int unsigned FH_W   = 13;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // Register reset values.
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Stencil weights: the centre weight plus the neighbor count is always KSUM.
  localparam int unsigned KSUM  = 8;
  localparam int unsigned SHIFT = 3;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [3*CHW-1:0] pix_t;

  // One line store entry: row r-2 above row r-1 at the same column.
  typedef struct packed {
    pix_t up;
    pix_t mid;
  } ent_t;

  // Position flags and coordinates of the item in the compute stage.
  typedef struct packed {
    logic          has_a;
    logic          has_b;
    logic          has_c;
    logic          c_ge1;
    logic          c_ge2;
    logic          c_lt_last;
    logic          r_ge1;
    logic          r_ge2;
    logic [XW-1:0] x;
    logic [XW-1:0] xm1;
    logic [YW-1:0] y;
    logic [YW-1:0] ym1;
  } pos_t;

  // Everything the arithmetic needs for one input word.
  typedef struct packed {
    pos_t pos;
    pix_t cur;
    pix_t ctr;
    pix_t up;
    pix_t right;
    pix_t rec0;
    pix_t rec1;
    pix_t rec2;
  } stencil_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    pix_t          pix;
    logic          done;
  } res_t;

endpackage

>>> rtl/cssu_regs.sv
module cssu_regs #(
  parameter int unsigned MAX_WIDTH  = cssu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = cssu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cssu_pkg::ADDR_W-1:0]     paddr,
  input  logic [cssu_pkg::DATA_W-1:0]     pwdata,
  output logic [cssu_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output logic [$clog2(MAX_WIDTH)-1:0]    wlast_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]   hlast_o,
  output logic                            restart_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [cssu_pkg::FW_W-1:0] fw_q, fw_d;
  logic [cssu_pkg::FH_W-1:0] fh_q, fh_d;
  cssu_pkg::reg_idx_e        idx;
  logic                      wr;

  assign pready = 1'b1;
  assign idx    = cssu_pkg::reg_idx_e'(paddr[2]);
  assign wr     = psel && penable && pwrite;

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    if (wr) begin
      unique case (idx)
        cssu_pkg::REG_FRAME_WIDTH:  fw_d = pwdata[cssu_pkg::FW_W-1:0];
        cssu_pkg::REG_FRAME_HEIGHT: fh_d = pwdata[cssu_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= cssu_pkg::FRAME_WIDTH_RST;
      fh_q <= cssu_pkg::FRAME_HEIGHT_RST;
    end else begin
      fw_q <= fw_d;
      fh_q <= fh_d;
    end
  end

  always_comb begin
    unique case (idx)
      cssu_pkg::REG_FRAME_WIDTH:  prdata = cssu_pkg::DATA_W'(fw_q);
      cssu_pkg::REG_FRAME_HEIGHT: prdata = cssu_pkg::DATA_W'(fh_q);
      default:                    prdata = '0;
    endcase
  end

  // Sizes outside the supported range are clamped to 1..MAX.
  always_comb begin
    if (fw_q == '0) begin
      wlast_o = '0;
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      wlast_o = CW'(MAX_WIDTH - 1);
    end else begin
      wlast_o = CW'(fw_q - 1'b1);
    end
  end

  always_comb begin
    if (fh_q == '0) begin
      hlast_o = '0;
    end else if (32'(fh_q) > 32'(MAX_HEIGHT)) begin
      hlast_o = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast_o = RW'(fh_q - 1'b1);
    end
  end

  // Any register write starts a new frame.
  assign restart_o = wr;

endmodule

>>> rtl/cssu_line.sv
module cssu_line #(
  parameter int unsigned MAX_WIDTH  = cssu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = cssu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  cssu_pkg::pix_t                pix_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wlast_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] hlast_i,
  input  logic                          restart_i,
  input  logic                          s1_fire_i,
  output logic                          s1_valid_o,
  output cssu_pkg::stencil_t            st_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // Position of the next input word.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;
  logic [CW-1:0] ra_d;
  cssu_pkg::pos_t pos_d;

  // Compute stage.
  logic           s1_valid_q;
  cssu_pkg::pos_t s1_pos_q;
  cssu_pkg::pix_t s1_cur_q;
  logic [CW-1:0]  s1_col_q;
  logic [CW-1:0]  s1_ra_q;
  logic           s1_hit_q;
  cssu_pkg::ent_t s1_byp_q;

  // Line store and its read port.
  cssu_pkg::ent_t line_mem [MAX_WIDTH];
  cssu_pkg::ent_t rd_q;
  cssu_pkg::ent_t ent_n;
  cssu_pkg::ent_t ec_q;
  cssu_pkg::ent_t wd;
  logic           we;

  cssu_pkg::pix_t rec0_q, rec1_q, rec2_q;

  assign col_m1 = col_q - CW'(1);
  assign row_m1 = row_q - RW'(1);

  // The look-ahead read fetches the entry the next word will need.
  assign ra_d = (col_q == wlast_i) ? '0 : col_q + CW'(1);

  always_comb begin
    pos_d.c_ge1     = (col_q != '0);
    pos_d.c_ge2     = (col_q >= CW'(2));
    pos_d.c_lt_last = (col_q != wlast_i);
    pos_d.r_ge1     = (row_q != '0);
    pos_d.r_ge2     = (row_q >= RW'(2));
    pos_d.has_a     = (row_q != '0);
    pos_d.has_b     = (row_q == hlast_i) && (col_q != '0);
    pos_d.has_c     = (row_q == hlast_i) && (col_q == wlast_i);
    pos_d.x         = cssu_pkg::XW'(col_q);
    pos_d.xm1       = cssu_pkg::XW'(col_m1);
    pos_d.y         = cssu_pkg::YW'(row_q);
    pos_d.ym1       = cssu_pkg::YW'(row_m1);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire_i) begin
      if (col_q == wlast_i) begin
        col_d = '0;
        row_d = (row_q == hlast_i) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_fire_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // A write in the same cycle as the read returns old data, so keep a bypass.
  assign we = s1_fire_i;
  assign wd = '{up: ec_q.mid, mid: s1_cur_q};

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_pos_q <= pos_d;
      s1_cur_q <= pix_i;
      s1_col_q <= col_q;
      s1_ra_q  <= ra_d;
      s1_hit_q <= we && (s1_col_q == ra_d);
      s1_byp_q <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      line_mem[s1_col_q] <= wd;
    end
    if (in_fire_i) begin
      rd_q <= line_mem[ra_d];
    end
  end

  assign ent_n = s1_hit_q ? s1_byp_q : rd_q;

  // The fetched entry becomes the centre entry of the next word; with a one-pixel
  // row it is the entry this word writes.
  always_ff @(posedge clk_i) begin
    if (s1_fire_i) begin
      ec_q <= (s1_col_q == s1_ra_q) ? wd : ent_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec0_q <= '0;
      rec1_q <= '0;
      rec2_q <= '0;
    end else if (s1_fire_i) begin
      rec2_q <= ec_q.mid;
      rec1_q <= rec0_q;
      rec0_q <= s1_cur_q;
    end
  end

  assign s1_valid_o = s1_valid_q;

  always_comb begin
    st_o.pos   = s1_pos_q;
    st_o.cur   = s1_cur_q;
    st_o.ctr   = ec_q.mid;
    st_o.up    = ec_q.up;
    st_o.right = ent_n.mid;
    st_o.rec0  = rec0_q;
    st_o.rec1  = rec1_q;
    st_o.rec2  = rec2_q;
  end

  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> s1_valid_q)
    else $error("Accepted word did not reach the compute stage.");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire_i && !in_fire_i) |=> (s1_valid_q && $stable(s1_col_q)))
    else $error("Compute stage lost a stalled word.");

endmodule

>>> rtl/cssu_kernel.sv
module cssu_kernel (
  input  cssu_pkg::stencil_t      st_i,
  output cssu_pkg::res_t [2:0]    res_o,
  output logic [1:0]              nres_o
);

  function automatic cssu_pkg::pix_t smooth(cssu_pkg::pix_t ctr,
                                            cssu_pkg::pix_t [3:0] nb,
                                            logic [3:0] en);
    logic [3:0]     wgt;
    logic [11:0]    sum;
    cssu_pkg::pix_t res;
    wgt = 4'(cssu_pkg::KSUM) - 4'($countones(en));
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 12'(ctr[ch*cssu_pkg::CHW +: cssu_pkg::CHW]) * 12'(wgt);
      for (int i = 0; i < 4; i++) begin
        if (en[i]) begin
          sum = sum + 12'(nb[i][ch*cssu_pkg::CHW +: cssu_pkg::CHW]);
        end
      end
      res[ch*cssu_pkg::CHW +: cssu_pkg::CHW] = sum[cssu_pkg::SHIFT +: cssu_pkg::CHW];
    end
    return res;
  endfunction

  cssu_pkg::pos_t pos;
  cssu_pkg::res_t ra, rb, rc;

  assign pos = st_i.pos;

  // Pixel one row up: left, right, top and the new pixel below.
  always_comb begin
    ra.x    = pos.x;
    ra.y    = pos.ym1;
    ra.done = 1'b0;
    ra.pix  = smooth(st_i.ctr, {st_i.cur, st_i.up, st_i.right, st_i.rec2},
                     {1'b1, pos.r_ge2, pos.c_lt_last, pos.c_ge1});
  end

  // Bottom row, pixel to the left of the new one: the new pixel, the pixel above
  // it and the pixel further left.
  always_comb begin
    rb.x    = pos.xm1;
    rb.y    = pos.y;
    rb.done = 1'b0;
    rb.pix  = smooth(st_i.rec0, {st_i.cur, st_i.rec2, st_i.rec1, st_i.rec1},
                     {1'b1, pos.r_ge1, pos.c_ge2, 1'b0});
  end

  // Final pixel of the frame.
  always_comb begin
    rc.x    = pos.x;
    rc.y    = pos.y;
    rc.done = 1'b1;
    rc.pix  = smooth(st_i.cur, {st_i.ctr, st_i.ctr, st_i.ctr, st_i.rec0},
                     {1'b0, 1'b0, pos.r_ge1, pos.c_ge1});
  end

  // Pack the present results to the low slots, in order.
  always_comb begin
    res_o[0] = pos.has_a ? ra : (pos.has_b ? rb : rc);
    res_o[1] = (pos.has_a && pos.has_b) ? rb : rc;
    res_o[2] = rc;
    nres_o   = 2'($countones({pos.has_a, pos.has_b, pos.has_c}));
  end

endmodule

>>> rtl/cssu_outq.sv
module cssu_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  cssu_pkg::res_t [2:0]   res_i,
  input  logic [1:0]             nres_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output cssu_pkg::res_t         res_o,
  output logic                   run_last_o
);

  cssu_pkg::res_t [2:0] q_q, q_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign res_o       = q_q[0];
  assign run_last_o  = (cnt_q == 2'd1);

  always_comb begin
    q_d   = q_q;
    cnt_d = cnt_q;
    if (load_i) begin
      q_d   = res_i;
      cnt_d = nres_i;
    end else if (pop) begin
      q_d[0] = q_q[1];
      q_d[1] = q_q[2];
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  a_load_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i)))
    else $error("Results loaded over undelivered words.");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cnt_q == 2'd1) && !load_i) |=> !out_valid_o)
    else $error("Result queue did not drain after its last word.");

endmodule

>>> rtl/cross_stencil_rgb_smoothing_unit.sv
// Channel   Direction  Handshake                     Word
// pixel     in         in_valid_i / in_ready_o       red_i, green_i, blue_i
// result    out        out_valid_o / out_ready_i     out_x_o .. frame_done_o
// config    in         APB psel/penable, pready = 1  frame_width, frame_height
//
// One pixel word is taken per clock while the compute stage can move on; its result
// words pass the compute stage register, then the result queue. The line store's one
// read and one write per cycle set that rate. Rows between the first and the bottom
// give one result word per pixel, the first row none; bottom-row pixels give up to
// two, the final pixel up to three, so the input stalls even with a ready sink. Reset
// clears the counters, pipeline and result queue; the line store needs no clearing.
module cross_stencil_rgb_smoothing_unit #(
  parameter int unsigned MAX_WIDTH  = cssu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = cssu_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cssu_pkg::ADDR_W-1:0] paddr,
  input  logic [cssu_pkg::DATA_W-1:0] pwdata,
  output logic [cssu_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cssu_pkg::XW-1:0]     out_x_o,
  output logic [cssu_pkg::YW-1:0]     out_y_o,
  output logic [7:0]                  out_red_o,
  output logic [7:0]                  out_green_o,
  output logic [7:0]                  out_blue_o,
  output logic                        run_last_o,
  output logic                        frame_done_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]        wlast;
  logic [RW-1:0]        hlast;
  logic                 restart;
  logic                 in_fire;
  logic                 s1_valid;
  logic                 s1_fire;
  logic                 can_load;
  cssu_pkg::stencil_t   st;
  cssu_pkg::res_t [2:0] res;
  logic [1:0]           nres;
  cssu_pkg::res_t       res_out;

  cssu_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .wlast_o   (wlast),
    .hlast_o   (hlast),
    .restart_o (restart)
  );

  // The compute stage moves on when its words fit in the result queue; a pixel
  // with no result (the first row) always moves on.
  assign s1_fire    = s1_valid && ((nres == 2'd0) || can_load);
  assign in_ready_o = !s1_valid || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  cssu_line #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .pix_i      ({red_i, green_i, blue_i}),
    .wlast_i    (wlast),
    .hlast_i    (hlast),
    .restart_i  (restart),
    .s1_fire_i  (s1_fire),
    .s1_valid_o (s1_valid),
    .st_o       (st)
  );

  cssu_kernel u_kernel (
    .st_i   (st),
    .res_o  (res),
    .nres_o (nres)
  );

  cssu_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire && (nres != 2'd0)),
    .res_i       (res),
    .nres_i      (nres),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out),
    .run_last_o  (run_last_o)
  );

  assign out_x_o      = res_out.x;
  assign out_y_o      = res_out.y;
  assign out_red_o    = res_out.pix[23:16];
  assign out_green_o  = res_out.pix[15:8];
  assign out_blue_o   = res_out.pix[7:0];
  assign frame_done_o = res_out.done;

endmodule
